### sv/pc_pkg.sv
package pc_pkg;

  localparam int VALUE_BITS = 16;
  // candidate divisors never pass sqrt of the largest value plus one
  localparam int DVS_BITS   = VALUE_BITS / 2 + 1;
  // running divisor sum stays at most three times the value before it is flagged over
  localparam int SUM_BITS   = VALUE_BITS + 2;
  localparam int SQ_BITS    = VALUE_BITS + 2;
  localparam int CNT_BITS   = $clog2(VALUE_BITS);

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [DVS_BITS-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quot;
    logic [VALUE_BITS-1:0] rem;
  } div_rsp_t;

endpackage

### sv/prime_and_perfect_classifier_top.sv
// channel   ports                                  handshake
// input     in_value[15:0]                         start & !busy
// result    out_is_prime, out_is_perfect           out_valid, one-cycle strobe
//
// each item steps its candidate divisors through the shared restoring divider,
// one quotient bit per cycle per candidate
// busy stays high from the accepted beat until the result strobe
// rst_n is synchronous, active low; no clearing pass is needed
// results cannot be stalled and appear for a single cycle
module prime_and_perfect_classifier_top
  import pc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  output logic                  out_is_prime,
  output logic                  out_is_perfect
);

  div_req_t req;
  div_rsp_t rsp;

  pc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_is_prime   (out_is_prime),
    .out_is_perfect (out_is_perfect),
    .req            (req),
    .rsp            (rsp)
  );

  pc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

endmodule

### sv/pc_div.sv
module pc_div
  import pc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [VALUE_BITS-1:0] dvs_r, dvs_nxt;
  logic [VALUE_BITS:0]   shifted;
  logic [VALUE_BITS:0]   diff;
  logic                  ge;

  // restoring divide, one quotient bit per cycle
  assign shifted = {rem_r, quo_r[VALUE_BITS-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_BITS'(VALUE_BITS - 1);
      rem_nxt = '0;
      quo_nxt = req.dividend;
      dvs_nxt = VALUE_BITS'(req.divisor);
    end else if (run_r) begin
      rem_nxt = ge ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
      quo_nxt = {quo_r[VALUE_BITS-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

### sv/pc_ctrl.sv
module pc_ctrl
  import pc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  output logic                  out_is_prime,
  output logic                  out_is_perfect,
  output div_req_t              req,
  input  div_rsp_t              rsp
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_WAIT  = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [VALUE_BITS-1:0] n_r, n_nxt;
  logic [DVS_BITS-1:0]   d_r, d_nxt;
  logic [SQ_BITS-1:0]    sq_r, sq_nxt;
  logic [SUM_BITS-1:0]   sum_r, sum_nxt;
  logic                  comp_r, comp_nxt;
  logic                  over_r, over_nxt;
  logic                  vld_r, vld_nxt;
  logic                  prime_r, prime_nxt;
  logic                  perf_r, perf_nxt;
  logic [SUM_BITS-1:0]   add_co;
  logic [SUM_BITS-1:0]   sum_add;
  logic                  big_n;

  assign big_n   = n_r >= VALUE_BITS'(2);
  // cofactor counts once when it equals the divisor
  assign add_co  = (rsp.quot == VALUE_BITS'(d_r)) ? '0 : SUM_BITS'(rsp.quot);
  assign sum_add = sum_r + SUM_BITS'(d_r) + add_co;

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    sum_nxt   = sum_r;
    comp_nxt  = comp_r;
    over_nxt  = over_r;
    vld_nxt   = 1'b0;
    prime_nxt = prime_r;
    perf_nxt  = perf_r;
    req.start    = 1'b0;
    req.dividend = n_r;
    req.divisor  = d_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          n_nxt     = in_value;
          d_nxt     = DVS_BITS'(2);
          sq_nxt    = SQ_BITS'(4);
          sum_nxt   = SUM_BITS'(1);
          comp_nxt  = 1'b0;
          over_nxt  = 1'b0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sq_r <= SQ_BITS'(n_r)) begin
          req.start = 1'b1;
          state_nxt = ST_WAIT;
        end else begin
          vld_nxt   = 1'b1;
          prime_nxt = big_n && !comp_r;
          perf_nxt  = big_n && !over_r && (sum_r == SUM_BITS'(n_r));
          state_nxt = ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (rsp.done) begin
          if (rsp.rem == '0) begin
            comp_nxt = 1'b1;
            if (!over_r) begin
              sum_nxt = sum_add;
              if (sum_add > SUM_BITS'(n_r)) over_nxt = 1'b1;
            end
          end
          // (d+1)^2 = d^2 + 2d + 1
          sq_nxt    = sq_r + SQ_BITS'({d_r, 1'b1});
          d_nxt     = d_r + 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
    sum_r   <= sum_nxt;
    comp_r  <= comp_nxt;
    over_r  <= over_nxt;
    prime_r <= prime_nxt;
    perf_r  <= perf_nxt;
  end

  assign busy           = state_r != ST_IDLE;
  assign out_valid      = vld_r;
  assign out_is_prime   = prime_r;
  assign out_is_perfect = perf_r;

endmodule

### sv/pc_checker.sv
module pc_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_is_prime,
  input logic out_is_perfect
);

  // an accepted beat keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  // every item ends with exactly one strobe
  a_fell_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && !$past(out_valid))
    else $error("result strobe while busy or repeated");

  // no perfect number is prime
  a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_prime && out_is_perfect))
    else $error("result both prime and perfect");

endmodule

bind prime_and_perfect_classifier_top pc_checker u_pc_checker (.*);
